### sv/rsfc_pkg.sv
// Shared types and constants for the RS-485 frame stuffing codec.
// No dependencies; used by every module of the block.
package rsfc_pkg;

  // Line codes of the framing scheme
  localparam logic [7:0] MARK_BYTE  = 8'hD7;
  localparam logic [7:0] SYNC_BYTE  = 8'h29;
  localparam logic [7:0] STUFF_BYTE = 8'h00;

  // Header geometry: byte at index LEN_INDEX carries the payload length
  localparam logic [7:0] LEN_INDEX    = 8'd5;
  localparam logic [7:0] RESYNC_INDEX = 8'd2;
  localparam int unsigned HEADER_LEN   = 6;
  localparam int unsigned RESYNC_COUNT = 3;

  // Width used to compare the receive count against header plus length
  localparam int unsigned CMP_W = 9;

  // Default receive buffer depth
  localparam int unsigned BUF_DEPTH_DEFAULT = 256;

  // Transmit header position saturates here
  localparam logic [1:0] TX_POS_MAX = 2'd3;

  // Operation codes
  localparam logic OP_RX = 1'b0;
  localparam logic OP_TX = 1'b1;

  // One result item
  typedef struct packed {
    logic       line_valid;
    logic [7:0] line_byte;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       header_resync;
    logic       frame_done;
    logic       overflow;
    logic       last;
  } res_t;

  // Transmit side output: one or two result items
  typedef struct packed {
    res_t first;
    res_t second;
    logic two;
  } tx_res_t;

endpackage

### sv/rsfc_rx_deframer.sv
// Receive deframer: unstuffing, header resync, length capture, frame end and overflow.
// Depends on rsfc_pkg for codes, constants and the result type.
module rsfc_rx_deframer #(
  parameter int unsigned BUF_DEPTH = rsfc_pkg::BUF_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rx_step,
  input  logic              tx_step,
  input  logic [7:0]        data_byte,
  output rsfc_pkg::res_t    res
);

  localparam int unsigned CNT_W = $clog2(BUF_DEPTH + 1);

  logic [CNT_W-1:0] rx_count, rx_count_next;
  logic             escape_flag, escape_flag_next;
  logic [7:0]       length_field, length_field_next;

  logic                       store;
  logic [rsfc_pkg::CMP_W-1:0] count_ext;
  logic [rsfc_pkg::CMP_W-1:0] frame_end;

  // Decode one line byte against the current receive state
  always_comb begin
    res               = '0;
    res.last          = 1'b1;
    store             = 1'b0;
    rx_count_next     = rx_count;
    escape_flag_next  = escape_flag;
    length_field_next = length_field;

    if (rx_count >= CNT_W'(BUF_DEPTH)) begin
      res.overflow     = 1'b1;
      rx_count_next    = '0;
      escape_flag_next = 1'b0;
    end else begin
      case (data_byte)
        rsfc_pkg::MARK_BYTE: begin
          store            = 1'b1;
          escape_flag_next = 1'b1;
        end
        rsfc_pkg::SYNC_BYTE: begin
          if (escape_flag) begin
            res.header_resync = 1'b1;
            res.store_valid   = 1'b1;
            res.store_index   = rsfc_pkg::RESYNC_INDEX;
            res.store_byte    = rsfc_pkg::SYNC_BYTE;
            rx_count_next     = CNT_W'(rsfc_pkg::RESYNC_COUNT);
          end else begin
            store = 1'b1;
          end
          escape_flag_next = 1'b0;
        end
        rsfc_pkg::STUFF_BYTE: begin
          // drop a zero that follows a mark byte
          if (escape_flag) begin
            escape_flag_next = 1'b0;
          end else begin
            store = 1'b1;
          end
        end
        default: begin
          store            = 1'b1;
          escape_flag_next = 1'b0;
        end
      endcase

      if (store) begin
        res.store_valid = 1'b1;
        res.store_index = 8'(rx_count);
        res.store_byte  = data_byte;
        rx_count_next   = rx_count + CNT_W'(1);
        if (8'(rx_count) == rsfc_pkg::LEN_INDEX) begin
          length_field_next = data_byte;
        end
      end
    end

    // Close the frame once header plus payload has arrived
    count_ext = rsfc_pkg::CMP_W'(rx_count_next);
    frame_end = rsfc_pkg::CMP_W'(rsfc_pkg::HEADER_LEN)
              + rsfc_pkg::CMP_W'(length_field_next);
    if (!res.overflow && count_ext > rsfc_pkg::CMP_W'(rsfc_pkg::HEADER_LEN)
        && count_ext == frame_end) begin
      res.frame_done   = 1'b1;
      rx_count_next    = '0;
      escape_flag_next = 1'b0;
    end
  end

  // Advance receive state; a transmit item clears the escape flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_count     <= '0;
      escape_flag  <= 1'b0;
      length_field <= '0;
    end else if (rx_step) begin
      rx_count     <= rx_count_next;
      escape_flag  <= escape_flag_next;
      length_field <= length_field_next;
    end else if (tx_step) begin
      escape_flag  <= 1'b0;
    end
  end

endmodule

### sv/rsfc_tx_framer.sv
// Transmit framer: passes frame bytes and inserts a zero after a mark byte.
// Depends on rsfc_pkg for codes and result types.
module rsfc_tx_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              tx_step,
  input  logic [7:0]        data_byte,
  input  logic              tx_last,
  output rsfc_pkg::tx_res_t res
);

  logic [1:0] tx_position;
  logic       stuff;

  // Stuff only past the header and never after the final byte
  assign stuff = (tx_position == rsfc_pkg::TX_POS_MAX)
              && (data_byte == rsfc_pkg::MARK_BYTE) && !tx_last;

  always_comb begin
    res                   = '0;
    res.two               = stuff;
    res.first.line_valid  = 1'b1;
    res.first.line_byte   = data_byte;
    res.first.last        = !stuff;
    res.second.line_valid = 1'b1;
    res.second.line_byte  = rsfc_pkg::STUFF_BYTE;
    res.second.last       = 1'b1;
  end

  // Track header position, restart on the final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_position <= '0;
    end else if (tx_step) begin
      if (tx_last) begin
        tx_position <= '0;
      end else if (tx_position != rsfc_pkg::TX_POS_MAX) begin
        tx_position <= tx_position + 2'd1;
      end
    end
  end

endmodule

### sv/rsfc_out_buf.sv
// Two-entry result register: loads one or two result items per input item.
// Depends on rsfc_pkg for the result type.
module rsfc_out_buf (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           load_two,
  input  rsfc_pkg::res_t load_first,
  input  rsfc_pkg::res_t load_second,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output rsfc_pkg::res_t out_res
);

  logic [1:0]     fill;
  rsfc_pkg::res_t slot0, slot1;
  logic           pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (fill != 2'd0);
  assign out_res   = slot0;
  // Room for a new item once the held results drain this cycle
  assign can_load  = (fill == 2'd0) || (fill == 2'd1 && out_ready);

  // Hold count of pending results
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (load) begin
      fill <= load_two ? 2'd2 : 2'd1;
    end else if (pop) begin
      fill <= fill - 2'd1;
    end
  end

  // Load new results or shift the second one forward
  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= load_first;
      slot1 <= load_second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

### sv/rs485_frame_stuffing_codec.sv
// RS-485 frame stuffing codec top level: stream ports, mode select, result buffer.
// Depends on rsfc_pkg, rsfc_rx_deframer, rsfc_tx_framer and rsfc_out_buf.
//
// Half-duplex byte-stuffing framer/deframer. tuser selects the mode of each
// item: 0 = line byte received, 1 = frame byte to transmit (tlast marks the
// frame's final byte). A received byte yields one result; a transmitted byte
// yields one, or two when a 0x00 is stuffed after a 0xD7 past the header.
// Each item is decoded combinationally into a two-entry result register, so a
// new item is taken every cycle while the output side keeps up. Input is held
// back while both results of a stuffing item are pending, or while a pending
// result is not taken. No memory clearing pass is needed after reset.
module rs485_frame_stuffing_codec #(
  parameter int unsigned BUF_DEPTH = rsfc_pkg::BUF_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] op
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] line_byte, [15:8] store_index,
                                      // [23:16] store_byte
  output logic [4:0]  m_axis_tuser,   // [0] line_valid, [1] store_valid,
                                      // [2] header_resync, [3] frame_done,
                                      // [4] overflow
  output logic        m_axis_tlast
);

  logic              accept;
  logic              rx_step, tx_step;
  rsfc_pkg::res_t    rx_res;
  rsfc_pkg::tx_res_t tx_res;
  rsfc_pkg::res_t    first, out_res;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign rx_step = accept && (s_axis_tuser == rsfc_pkg::OP_RX);
  assign tx_step = accept && (s_axis_tuser == rsfc_pkg::OP_TX);

  rsfc_rx_deframer #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_rx (
    .clk       (clk),
    .rst       (rst),
    .rx_step   (rx_step),
    .tx_step   (tx_step),
    .data_byte (s_axis_tdata),
    .res       (rx_res)
  );

  rsfc_tx_framer u_tx (
    .clk       (clk),
    .rst       (rst),
    .tx_step   (tx_step),
    .data_byte (s_axis_tdata),
    .tx_last   (s_axis_tlast),
    .res       (tx_res)
  );

  // Select the result of the active mode
  assign first = (s_axis_tuser == rsfc_pkg::OP_TX) ? tx_res.first : rx_res;

  rsfc_out_buf u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (accept),
    .load_two    (tx_step && tx_res.two),
    .load_first  (first),
    .load_second (tx_res.second),
    .can_load    (s_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (out_res)
  );

  // Pack the result item onto the master stream
  assign m_axis_tdata = {out_res.store_byte, out_res.store_index, out_res.line_byte};
  assign m_axis_tuser = {out_res.overflow, out_res.frame_done, out_res.header_resync,
                         out_res.store_valid, out_res.line_valid};
  assign m_axis_tlast = out_res.last;

endmodule
